@@ hdl/srfmd_pkg.sv @@
// Shared constants and types for the serial frame router / motor drive block.
// No dependencies.
`timescale 1ns / 1ps

package srfmd_pkg;

  localparam int BYTE_W  = 8;
  localparam int CHAN_W  = 2;
  localparam int POS_W   = 3;
  localparam int CIDX_W  = 3;
  localparam int BURST_N = 6;   // ack + address + four data bytes
  localparam int CNT_W   = 3;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_SYNC  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_ACK   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_LED   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_SERVO = 3'd3;
  localparam logic [CIDX_W-1:0] REG_MOTOR = 3'd4;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] SYNC_RST  = 8'h80;
  localparam logic [BYTE_W-1:0] ACK_RST   = 8'h33;
  localparam logic [BYTE_W-1:0] LED_RST   = 8'h10;
  localparam logic [BYTE_W-1:0] SERVO_RST = 8'h20;
  localparam logic [BYTE_W-1:0] MOTOR_RST = 8'h30;

  // Largest duty value (magnitude of -128)
  localparam logic [BYTE_W-1:0] DUTY_MAX = 8'h80;

  typedef enum logic [CHAN_W-1:0] {
    CH_HOST  = 2'd0,
    CH_LED   = 2'd1,
    CH_SERVO = 2'd2,
    CH_MOTOR = 2'd3
  } channel_t;

  // Frame position: hunting, then bytes expected so far
  typedef enum logic [POS_W-1:0] {
    POS_HUNT = 3'd0,
    POS_ADDR = 3'd1,
    POS_D0   = 3'd2,
    POS_D1   = 3'd3,
    POS_D2   = 3'd4,
    POS_D3   = 3'd5
  } frame_pos_t;

endpackage

@@ hdl/serial_frame_router_motor_drive_unit.sv @@
// Serial frame router with motor drive: top level.
// Depends on srfmd_pkg.
`timescale 1ns / 1ps

// Host bytes enter one beat per cycle on the in_ channel. The block hunts
// for the sync byte, then collects an address byte and four data bytes; a
// sync value inside a frame is plain data. The byte that completes a frame
// loads a result burst into a shift register on the out_ side: an ack beat
// on channel 0, then either the address and the four data bytes on the LED
// or servo channel (6 beats), a single motor-update beat on channel 3
// (2 beats), or nothing more (1 beat). The first beat is offered the cycle
// after the completing byte is taken. The burst drains one beat per cycle
// while out_ready is high; out_last marks its final beat. Every beat carries
// the motor pins and duty as they stand after that beat, so the ack shows
// the motor state from before the frame. Bytes are taken every cycle,
// including while a burst drains; only the byte that would complete the
// next frame is held off (in_ready low) while the previous burst still has
// beats waiting. It is taken in the same cycle as that burst's last beat
// leaves (in_ready then follows out_ready), so a six-byte frame and its
// burst of at most six beats overlap: while the receiver keeps up, the burst
// drains as the next frame comes in and no byte is held off. Configuration
// registers are written with cfg_wr_en; indexes past the motor address are
// ignored. Reset is synchronous and active low.

module serial_frame_router_motor_drive_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // host byte input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [srfmd_pkg::BYTE_W-1:0]   in_host_byte,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [srfmd_pkg::CHAN_W-1:0]   out_channel,
  output logic [srfmd_pkg::BYTE_W-1:0]   out_out_byte,
  output logic                           out_dir_a,
  output logic                           out_dir_b,
  output logic [srfmd_pkg::BYTE_W-1:0]   out_duty,
  output logic                           out_last,
  // configuration writes
  input  logic                           cfg_wr_en,
  input  logic [srfmd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [srfmd_pkg::BYTE_W-1:0]   cfg_wdata
);

  import srfmd_pkg::*;

  // configuration
  logic [BYTE_W-1:0] sync_r, ack_r, led_r, servo_r, motor_r;

  // frame capture
  frame_pos_t        pos_r, pos_nxt;
  logic [BYTE_W-1:0] addr_r;
  logic [BYTE_W-1:0] data_r [0:2];   // data 3 never needs storing

  // motor state (value after the most recent update)
  logic              pin_a_r, pin_b_r;
  logic [BYTE_W-1:0] duty_r;

  // result burst
  logic              bst_valid_r;
  logic              bst_first_r;
  logic [CNT_W-1:0]  bst_rem_r;
  channel_t          bst_ch_r;
  logic [BYTE_W-1:0] bst_bytes_r [0:BURST_N-1];
  logic              old_a_r, old_b_r;
  logic [BYTE_W-1:0] old_duty_r;

  logic in_fire, out_fire, frame_done;

  assign out_fire   = bst_valid_r && out_ready;
  // frame-completing byte may enter as the last beat of the old burst leaves
  assign in_ready   = !(bst_valid_r && (pos_r == POS_D3)) || (out_fire && out_last);
  assign in_fire    = in_valid && in_ready;
  assign frame_done = in_fire && (pos_r == POS_D3);

  // ---------------- frame routing decision ----------------
  logic              led_hit, servo_hit, motor_hit;
  channel_t          route_ch;
  logic [CNT_W-1:0]  route_cnt;
  logic              mot_en, spd_neg;
  logic              pin_a_nxt, pin_b_nxt;
  logic [BYTE_W-1:0] duty_nxt;

  always_comb begin
    led_hit   = (addr_r == led_r);
    servo_hit = (addr_r == servo_r);
    motor_hit = (addr_r == motor_r);
    route_ch  = led_hit ? CH_LED : (servo_hit ? CH_SERVO : CH_MOTOR);
    if (led_hit || servo_hit) begin
      route_cnt = CNT_W'(BURST_N);
    end else if (motor_hit) begin
      route_cnt = CNT_W'(2);
    end else begin
      route_cnt = CNT_W'(1);
    end
    // motor: data 0 is enable, data 1 is signed speed
    mot_en    = (data_r[0] != '0);
    spd_neg   = data_r[1][BYTE_W-1];
    pin_a_nxt = pin_a_r;
    pin_b_nxt = pin_b_r;
    duty_nxt  = duty_r;
    if (!led_hit && !servo_hit && motor_hit) begin
      if (mot_en) begin
        pin_a_nxt = spd_neg;
        pin_b_nxt = !spd_neg;
        duty_nxt  = spd_neg ? (~data_r[1] + 8'd1) : data_r[1];
      end else begin
        pin_a_nxt = 1'b0;
        pin_b_nxt = 1'b0;
      end
    end
  end

  // ---------------- frame position ----------------
  always_comb begin
    pos_nxt = pos_r;
    case (pos_r)
      POS_HUNT: pos_nxt = (in_host_byte == sync_r) ? POS_ADDR : POS_HUNT;
      POS_ADDR: pos_nxt = POS_D0;
      POS_D0:   pos_nxt = POS_D1;
      POS_D1:   pos_nxt = POS_D2;
      POS_D2:   pos_nxt = POS_D3;
      POS_D3:   pos_nxt = POS_HUNT;
      default:  pos_nxt = (in_host_byte == sync_r) ? POS_ADDR : POS_HUNT;
    endcase
  end

  // control and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r      <= SYNC_RST;
      ack_r       <= ACK_RST;
      led_r       <= LED_RST;
      servo_r     <= SERVO_RST;
      motor_r     <= MOTOR_RST;
      pos_r       <= POS_HUNT;
      pin_a_r     <= 1'b0;
      pin_b_r     <= 1'b0;
      duty_r      <= '0;
      bst_valid_r <= 1'b0;
      bst_first_r <= 1'b0;
      bst_rem_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SYNC:  sync_r  <= cfg_wdata;
          REG_ACK:   ack_r   <= cfg_wdata;
          REG_LED:   led_r   <= cfg_wdata;
          REG_SERVO: servo_r <= cfg_wdata;
          REG_MOTOR: motor_r <= cfg_wdata;
          default:   ;
        endcase
      end
      if (in_fire) begin
        pos_r <= pos_nxt;
      end
      if (frame_done) begin
        pin_a_r     <= pin_a_nxt;
        pin_b_r     <= pin_b_nxt;
        duty_r      <= duty_nxt;
        bst_valid_r <= 1'b1;
        bst_first_r <= 1'b1;
        bst_rem_r   <= route_cnt;
      end else if (out_fire) begin
        bst_first_r <= 1'b0;
        bst_rem_r   <= bst_rem_r - CNT_W'(1);
        if (bst_rem_r == CNT_W'(1)) begin
          bst_valid_r <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      case (pos_r)
        POS_ADDR: addr_r    <= in_host_byte;
        POS_D0:   data_r[0] <= in_host_byte;
        POS_D1:   data_r[1] <= in_host_byte;
        POS_D2:   data_r[2] <= in_host_byte;
        default:  ;
      endcase
    end
    if (frame_done) begin
      bst_ch_r       <= route_ch;
      old_a_r        <= pin_a_r;
      old_b_r        <= pin_b_r;
      old_duty_r     <= duty_r;
      bst_bytes_r[0] <= ack_r;
      // motor update beat carries a zero byte
      bst_bytes_r[1] <= (led_hit || servo_hit) ? addr_r : '0;
      bst_bytes_r[2] <= data_r[0];
      bst_bytes_r[3] <= data_r[1];
      bst_bytes_r[4] <= data_r[2];
      bst_bytes_r[5] <= in_host_byte;
    end else if (out_fire) begin
      for (int i = 0; i < BURST_N - 1; i++) begin
        bst_bytes_r[i] <= bst_bytes_r[i+1];
      end
    end
  end

  // output view of the head of the burst
  assign out_valid    = bst_valid_r;
  assign out_channel  = bst_first_r ? CH_HOST : bst_ch_r;
  assign out_out_byte = bst_bytes_r[0];
  assign out_dir_a    = bst_first_r ? old_a_r : pin_a_r;
  assign out_dir_b    = bst_first_r ? old_b_r : pin_b_r;
  assign out_duty     = bst_first_r ? old_duty_r : duty_r;
  assign out_last     = (bst_rem_r == CNT_W'(1));

endmodule

@@ hdl/srfmd_checker.sv @@
// Port-level checks for the serial frame router / motor drive block.
// Depends on srfmd_pkg; bound to serial_frame_router_motor_drive_unit.
`timescale 1ns / 1ps

module srfmd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [srfmd_pkg::BYTE_W-1:0]   in_host_byte,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [srfmd_pkg::CHAN_W-1:0]   out_channel,
  input logic [srfmd_pkg::BYTE_W-1:0]   out_out_byte,
  input logic                           out_dir_a,
  input logic                           out_dir_b,
  input logic [srfmd_pkg::BYTE_W-1:0]   out_duty,
  input logic                           out_last,
  input logic                           cfg_wr_en,
  input logic [srfmd_pkg::CIDX_W-1:0]   cfg_index,
  input logic [srfmd_pkg::BYTE_W-1:0]   cfg_wdata
);

  import srfmd_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_byte)
      && $stable(out_channel) && $stable(out_last))
    else $error("result beat changed while stalled");

  // motor update is a single zero beat closing the burst
  a_motor_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_channel == CH_MOTOR) |-> out_last && (out_out_byte == '0))
    else $error("bad motor update beat");

  // pins never both driven, duty in range, reverse (dir_a) implies nonzero duty
  a_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_dir_a && out_dir_b) && (out_duty <= DUTY_MAX)
      && (!out_dir_a || (out_duty != '0)))
    else $error("inconsistent motor state");

  // an ack that is not last is followed at once by a routed beat
  a_ack_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_channel == CH_HOST) && !out_last
      |=> out_valid && (out_channel != CH_HOST))
    else $error("ack not followed by routed beat");

endmodule

bind serial_frame_router_motor_drive_unit srfmd_checker u_srfmd_checker (.*);

@@ verif/frame_route_checker.sv @@
// Scoreboard for the serial frame router / motor drive unit: tracks frames and
// motor state from observed input and config beats, checks every result beat.
// Depends on srfmd_pkg.
`timescale 1ns / 1ps

module frame_route_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [srfmd_pkg::BYTE_W-1:0]   in_host_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [srfmd_pkg::CHAN_W-1:0]   out_channel,
  input  logic [srfmd_pkg::BYTE_W-1:0]   out_out_byte,
  input  logic                           out_dir_a,
  input  logic                           out_dir_b,
  input  logic [srfmd_pkg::BYTE_W-1:0]   out_duty,
  input  logic                           out_last,
  input  logic                           cfg_wr_en,
  input  logic [srfmd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [srfmd_pkg::BYTE_W-1:0]   cfg_wdata,
  output int                             mismatches,
  output int                             beats_left,
  output int                             beats_checked,
  output int                             led_frames,
  output int                             servo_frames,
  output int                             motor_frames,
  output int                             ack_only_frames
);

  import srfmd_pkg::*;

  typedef struct packed {
    channel_t          chan;
    logic [BYTE_W-1:0] data;
    logic              dir_a;
    logic              dir_b;
    logic [BYTE_W-1:0] duty;
    logic              last;
  } link_beat_t;

  // register copies
  logic [BYTE_W-1:0] sync_r, ack_r, led_r, servo_r, motor_r;

  // frame and motor state
  frame_pos_t        frame_pos;
  logic [BYTE_W-1:0] frame_addr;
  logic [BYTE_W-1:0] frame_body [4];
  logic              pin_a, pin_b;
  logic [BYTE_W-1:0] duty_lvl;

  link_beat_t link_beats [$];

  task automatic queue_beat(input channel_t ch, input logic [BYTE_W-1:0] b);
    link_beat_t nb;
    nb = '{chan: ch, data: b, dir_a: pin_a, dir_b: pin_b, duty: duty_lvl, last: 1'b0};
    link_beats.push_back(nb);
  endtask

  task automatic route_frame();
    channel_t   link;
    link_beat_t tail;
    queue_beat(CH_HOST, ack_r);
    if (frame_addr == led_r || frame_addr == servo_r) begin
      // LED wins over servo when both addresses match
      link = (frame_addr == led_r) ? CH_LED : CH_SERVO;
      if (link == CH_LED) led_frames++;
      else servo_frames++;
      queue_beat(link, frame_addr);
      for (int i = 0; i < 4; i++) queue_beat(link, frame_body[i]);
    end else if (frame_addr == motor_r) begin
      if (frame_body[0] != '0) begin
        if (frame_body[1][BYTE_W-1]) begin
          pin_a    = 1'b1;
          pin_b    = 1'b0;
          duty_lvl = 8'd0 - frame_body[1];
        end else begin
          pin_a    = 1'b0;
          pin_b    = 1'b1;
          duty_lvl = frame_body[1];
        end
      end else begin
        // disable: pins low, duty kept
        pin_a = 1'b0;
        pin_b = 1'b0;
      end
      motor_frames++;
      queue_beat(CH_MOTOR, 8'h00);
    end else begin
      ack_only_frames++;
    end
    tail      = link_beats.pop_back();
    tail.last = 1'b1;
    link_beats.push_back(tail);
  endtask

  task automatic take_host_byte(input logic [BYTE_W-1:0] b);
    case (frame_pos)
      POS_ADDR: begin
        frame_addr = b;
        frame_pos  = POS_D0;
      end
      POS_D0, POS_D1, POS_D2: begin
        frame_body[2'(frame_pos - POS_D0)] = b;
        frame_pos = frame_pos_t'(frame_pos + 1);
      end
      POS_D3: begin
        frame_body[3] = b;
        frame_pos     = POS_HUNT;
        route_frame();
      end
      default: frame_pos = (b == sync_r) ? POS_ADDR : POS_HUNT;
    endcase
  endtask

  task automatic check_beat();
    link_beat_t want;
    if (link_beats.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected beat, exp none / got ch=%0d byte=%h a=%b b=%b duty=%h last=%b",
               $time, out_channel, out_out_byte, out_dir_a, out_dir_b, out_duty, out_last);
    end else begin
      want = link_beats.pop_front();
      beats_checked++;
      if (want.chan !== out_channel || want.data !== out_out_byte ||
          want.dir_a !== out_dir_a || want.dir_b !== out_dir_b ||
          want.duty !== out_duty || want.last !== out_last) begin
        mismatches++;
        $display("%0t: beat mismatch exp ch=%0d byte=%h a=%b b=%b duty=%h last=%b",
                 $time, want.chan, want.data, want.dir_a, want.dir_b, want.duty,
                 want.last);
        $display("%0t:                got ch=%0d byte=%h a=%b b=%b duty=%h last=%b",
                 $time, out_channel, out_out_byte, out_dir_a, out_dir_b, out_duty,
                 out_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_r          = SYNC_RST;
      ack_r           = ACK_RST;
      led_r           = LED_RST;
      servo_r         = SERVO_RST;
      motor_r         = MOTOR_RST;
      frame_pos       = POS_HUNT;
      pin_a           = 1'b0;
      pin_b           = 1'b0;
      duty_lvl        = '0;
      mismatches      = 0;
      beats_checked   = 0;
      led_frames      = 0;
      servo_frames    = 0;
      motor_frames    = 0;
      ack_only_frames = 0;
      link_beats.delete();
    end else begin
      // output first: a beat leaving now belongs to an older byte
      if (out_valid && out_ready) check_beat();
      if (in_valid && in_ready) take_host_byte(in_host_byte);
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SYNC:  sync_r  = cfg_wdata;
          REG_ACK:   ack_r   = cfg_wdata;
          REG_LED:   led_r   = cfg_wdata;
          REG_SERVO: servo_r = cfg_wdata;
          REG_MOTOR: motor_r = cfg_wdata;
          default: ;
        endcase
      end
    end
    beats_left = link_beats.size();
  end

endmodule

@@ verif/tb_serial_frame_router_motor_drive_unit.sv @@
// Testbench top for serial_frame_router_motor_drive_unit: clock, reset, host
// byte and config stimulus, result back-pressure, verdict.
// Depends on srfmd_pkg, frame_route_checker and the unit itself.
`timescale 1ns / 1ps

module tb_serial_frame_router_motor_drive_unit;
  import srfmd_pkg::*;

  localparam int IDLE_PCT     = 14;        // gap / stall chance per cycle, percent
  localparam int HOLD_CYCLES  = 200;       // long receiver hold-off
  localparam int DRAIN_CYCLES = 12;        // > burst length plus pipeline slack
  localparam int PHASE_ITEMS  = 63;        // minimum host bytes per random phase
  localparam int LIMIT_NS     = 2_000_000; // hard timeout, far above a slow run
  localparam logic [CIDX_W-1:0] REG_UNUSED = REG_MOTOR + 3'd1;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_host_byte;
  logic              out_valid;
  logic              out_ready;
  logic [CHAN_W-1:0] out_channel;
  logic [BYTE_W-1:0] out_out_byte;
  logic              out_dir_a;
  logic              out_dir_b;
  logic [BYTE_W-1:0] out_duty;
  logic              out_last;
  logic              cfg_wr_en;
  logic [CIDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0] cfg_wdata;

  int mismatches, beats_left, beats_checked;
  int led_frames, servo_frames, motor_frames, ack_only_frames;

  // stimulus-side knowledge of the programmed registers (used to aim frames)
  logic [BYTE_W-1:0] cur_sync  = SYNC_RST;
  logic [BYTE_W-1:0] cur_led   = LED_RST;
  logic [BYTE_W-1:0] cur_servo = SERVO_RST;
  logic [BYTE_W-1:0] cur_motor = MOTOR_RST;

  int items_sent   = 0;
  int settings_run = 0;
  bit calm         = 1'b0;   // no gaps on either side while set
  int holds_asked  = 0;      // bumped by stimulus, served by the ready process
  int holds_served = 0;

  serial_frame_router_motor_drive_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_host_byte (in_host_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_channel  (out_channel),
    .out_out_byte (out_out_byte),
    .out_dir_a    (out_dir_a),
    .out_dir_b    (out_dir_b),
    .out_duty     (out_duty),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  frame_route_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_host_byte    (in_host_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_out_byte    (out_out_byte),
    .out_dir_a       (out_dir_a),
    .out_dir_b       (out_dir_b),
    .out_duty        (out_duty),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .beats_left      (beats_left),
    .beats_checked   (beats_checked),
    .led_frames      (led_frames),
    .servo_frames    (servo_frames),
    .motor_frames    (motor_frames),
    .ack_only_frames (ack_only_frames)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #(LIMIT_NS);
    $display("%0t: timeout, %0d result beats still outstanding", $time, beats_left);
    $display("simulation failed");
    $finish;
  end

  // Result side back-pressure. Random stalls at about IDLE_PCT percent; when
  // stimulus asks for a hold-off, ready stays low for HOLD_CYCLES so the
  // result shift register fills and the unit must stall the input side.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // One host byte beat. Random gaps go in front; valid stays up from the
  // accepting edge straight into the next beat when no gap is drawn.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_host_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] addr, d0, d1, d2, d3);
    send_byte(cur_sync);
    send_byte(addr);
    send_byte(d0);
    send_byte(d1);
    send_byte(d2);
    send_byte(d3);
  endtask

  // Drop valid, wait for every predicted beat to leave, then let any
  // in-flight work settle before touching the registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CIDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Writes all five registers back to back, plus one write to an index past
  // the register file that the unit must ignore.
  task automatic program_regs(input logic [BYTE_W-1:0] s, a, l, sv, m);
    cfg_beat(REG_SYNC, s);
    cfg_beat(REG_ACK, a);
    cfg_beat(REG_LED, l);
    cfg_beat(REG_SERVO, sv);
    cfg_beat(REG_MOTOR, m);
    cfg_beat(CIDX_W'($urandom_range(2 ** CIDX_W - 1, REG_UNUSED)),
             BYTE_W'($urandom_range(255)));
    cfg_wr_en <= 1'b0;
    cur_sync  = s;
    cur_led   = l;
    cur_servo = sv;
    cur_motor = m;
    settings_run++;
  endtask

  // Mostly well-formed frames aimed at the live addresses, with noise bytes,
  // truncated frames and sync values buried in the data mixed in.
  task automatic send_random_frame();
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] body [4];
    int                pick;
    // stray bytes while hunting (may themselves hit sync and shift framing)
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(3, 1)) send_byte(BYTE_W'($urandom_range(255)));
    // truncated frame: its tail swallows the next frame's head as data
    if ($urandom_range(15) == 0) begin
      send_byte(cur_sync);
      repeat ($urandom_range(3)) send_byte(BYTE_W'($urandom_range(255)));
    end
    for (int i = 0; i < 4; i++) body[i] = BYTE_W'($urandom_range(255));
    pick = $urandom_range(9);
    if (pick < 3)      addr = cur_led;
    else if (pick < 5) addr = cur_servo;
    else if (pick < 8) begin
      addr = cur_motor;
      if ($urandom_range(3) == 0) body[0] = 8'h00;
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(4))
          0:       body[1] = 8'h80;   // most negative speed
          1:       body[1] = 8'h7F;
          2:       body[1] = 8'h00;
          3:       body[1] = 8'hFF;
          default: body[1] = 8'h01;
        endcase
      end
    end else addr = BYTE_W'($urandom_range(255));
    if ($urandom_range(7) == 0) body[$urandom_range(3)] = cur_sync;
    send_frame(addr, body[0], body[1], body[2], body[3]);
  endtask

  task automatic run_phase(input logic [BYTE_W-1:0] s, a, l, sv, m,
                           input bit with_hold, input bit no_gaps);
    int start;
    wait_drained();
    program_regs(s, a, l, sv, m);
    calm  = no_gaps;
    start = items_sent;
    while (items_sent < start + PHASE_ITEMS) begin
      // long receiver hold-off partway in, while frames keep coming
      if (with_hold && holds_asked == 0 && items_sent >= start + 12) holds_asked++;
      send_random_frame();
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_host_byte <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= REG_SYNC;
    cfg_wdata    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset register values
    send_byte(8'hFF);                                            // dropped while hunting
    send_frame(LED_RST, SYNC_RST, 8'h00, 8'hFF, SYNC_RST);       // sync inside data
    send_frame(SERVO_RST, 8'h01, 8'h7F, 8'hFE, 8'h80);
    send_frame(MOTOR_RST, 8'h01, DUTY_MAX, 8'h00, 8'h00);        // -128 -> duty 128
    send_frame(MOTOR_RST, 8'h00, 8'h55, 8'hAA, 8'h00);           // disable keeps duty
    send_frame(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);               // unrouted, ack only

    // Random phases across register settings
    run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
              BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
              BYTE_W'($urandom_range(255)), 1'b1, 1'b0);
    run_phase(8'h00, 8'hFF, 8'hFF, 8'h01, 8'h00, 1'b0, 1'b0);   // extremes
    run_phase(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80, 1'b0, 1'b0);   // extremes, flipped
    begin : all_equal
      logic [BYTE_W-1:0] shared;
      shared = BYTE_W'($urandom_range(255));
      // all three addresses equal: every routed frame goes to LED
      run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                shared, shared, shared, 1'b0, 1'b0);
      // servo equals motor: servo wins
      run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                shared ^ 8'h55, shared, shared, 1'b0, 1'b0);
    end
    run_phase(SYNC_RST, ACK_RST, LED_RST, SERVO_RST, MOTOR_RST, 1'b0, 1'b1);  // no gaps
    run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
              BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
              BYTE_W'($urandom_range(255)), 1'b0, 1'b0);

    wait_drained();

    $display("covered %0d host bytes over %0d register settings, %0d result beats checked",
             items_sent, settings_run, beats_checked);
    $display("frames: %0d LED, %0d servo, %0d motor, %0d ack only",
             led_frames, servo_frames, motor_frames, ack_only_frames);
    if (beats_left != 0)
      $display("%0t: %0d expected result beats never arrived", $time, beats_left);
    if (mismatches == 0 && beats_left == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/srfmd_pkg.sv
hdl/serial_frame_router_motor_drive_unit.sv
hdl/srfmd_checker.sv
verif/frame_route_checker.sv
verif/tb_serial_frame_router_motor_drive_unit.sv
